@@ rtl/hfl_pkg.sv @@
// Shared types and constants for the two-state HMM forward cost block.
// Holds the item structs, the register map and the fixed field widths.
// No dependencies.
package hfl_pkg;

  localparam int FACE_WIDTH     = 3;
  localparam int COST_CFG_WIDTH = 16;
  localparam int EMIT_WIDTH     = 10;
  localparam int EMIT_TAB_WIDTH = 60;
  localparam int CFG_WIDTH      = 60;
  localparam int ADDR_WIDTH     = 3;
  localparam int SEQ_WIDTH      = 32;
  localparam int CORR_WIDTH     = 8;
  localparam int MAX_CORR       = 200;

  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] STEP_Q32 = 64'd4286586875;

  localparam logic [COST_CFG_WIDTH-1:0] CFG_COST_IMP = '1;
  localparam logic [EMIT_WIDTH-1:0]     EMIT_IMP     = '1;

  localparam logic [ADDR_WIDTH-1:0] REG_COST_STAY_FIRST      = 3'd0;
  localparam logic [ADDR_WIDTH-1:0] REG_COST_FIRST_TO_SECOND = 3'd1;
  localparam logic [ADDR_WIDTH-1:0] REG_COST_SECOND_TO_FIRST = 3'd2;
  localparam logic [ADDR_WIDTH-1:0] REG_COST_STAY_SECOND     = 3'd3;
  localparam logic [ADDR_WIDTH-1:0] REG_EMIT_TABLE_FIRST     = 3'd4;
  localparam logic [ADDR_WIDTH-1:0] REG_EMIT_TABLE_SECOND    = 3'd5;
  localparam logic [ADDR_WIDTH-1:0] REG_START_COST_FIRST     = 3'd6;
  localparam logic [ADDR_WIDTH-1:0] REG_START_COST_SECOND    = 3'd7;

  localparam logic [COST_CFG_WIDTH-1:0] RST_COST_STAY_FIRST      = 16'd13;
  localparam logic [COST_CFG_WIDTH-1:0] RST_COST_FIRST_TO_SECOND = 16'd767;
  localparam logic [COST_CFG_WIDTH-1:0] RST_COST_SECOND_TO_FIRST = 16'd767;
  localparam logic [COST_CFG_WIDTH-1:0] RST_COST_STAY_SECOND     = 16'd13;
  localparam logic [EMIT_TAB_WIDTH-1:0] RST_EMIT_TABLE_FIRST     = 60'd517293226407177675;
  localparam logic [EMIT_TAB_WIDTH-1:0] RST_EMIT_TABLE_SECOND    = 60'd199932528911464837;
  localparam logic [COST_CFG_WIDTH-1:0] RST_START_COST_FIRST     = 16'd0;
  localparam logic [COST_CFG_WIDTH-1:0] RST_START_COST_SECOND    = 16'd65535;

  typedef struct packed {
    logic [FACE_WIDTH-1:0] face;
    logic                  first_symbol;
    logic                  last_symbol;
  } sym_t;

  typedef struct packed {
    logic [SEQ_WIDTH-1:0] sequence_cost;
    logic                 impossible;
  } res_t;

  typedef struct packed {
    logic [COST_CFG_WIDTH-1:0] cost_stay_first;
    logic [COST_CFG_WIDTH-1:0] cost_first_to_second;
    logic [COST_CFG_WIDTH-1:0] cost_second_to_first;
    logic [COST_CFG_WIDTH-1:0] cost_stay_second;
    logic [EMIT_TAB_WIDTH-1:0] emit_table_first;
    logic [EMIT_TAB_WIDTH-1:0] emit_table_second;
    logic [COST_CFG_WIDTH-1:0] start_cost_first;
    logic [COST_CFG_WIDTH-1:0] start_cost_second;
  } cfg_t;

endpackage

@@ rtl/hfl_lse.sv @@
// Two-input log-sum-exp of costs: minimum less a correction from a constant table.
// The table is built at elaboration from truncated Q32 powers of exp(-1/512).
// Depends on hfl_pkg.
module hfl_lse
  import hfl_pkg::*;
#(
  parameter int COST_WIDTH       = 32,
  parameter int CORRECTION_DEPTH = 256
) (
  input  logic [COST_WIDTH-1:0] a,
  input  logic [COST_WIDTH-1:0] b,
  output logic [COST_WIDTH-1:0] y
);

  localparam int IW = (CORRECTION_DEPTH > 1) ? $clog2(CORRECTION_DEPTH) : 1;
  localparam logic [COST_WIDTH-1:0] IMP = '1;

  function automatic logic [CORRECTION_DEPTH*CORR_WIDTH-1:0] build_corr();
    logic [63:0] zo [MAX_CORR];
    logic [63:0] z;
    logic [63:0] yq;
    logic [CORRECTION_DEPTH*CORR_WIDTH-1:0] tab;
    int cnt;
    z   = ONE_Q32;
    tab = '0;
    for (int m = 1; m < 2 * MAX_CORR; m++) begin
      z = (z * STEP_Q32) >> 32;
      if (m[0]) begin
        zo[(m - 1) >> 1] = z;
      end
    end
    yq = ONE_Q32;
    for (int d = 0; d < CORRECTION_DEPTH; d++) begin
      if (d > 0) begin
        yq = (yq * STEP_Q32) >> 32;
        yq = (yq * STEP_Q32) >> 32;
      end
      cnt = 0;
      for (int k = 0; k < MAX_CORR; k++) begin
        if (zo[k] + ((yq * zo[k]) >> 32) >= ONE_Q32) begin
          cnt++;
        end
      end
      tab[d*CORR_WIDTH +: CORR_WIDTH] = CORR_WIDTH'(cnt);
    end
    return tab;
  endfunction

  localparam logic [CORRECTION_DEPTH*CORR_WIDTH-1:0] CORR = build_corr();

  logic [COST_WIDTH-1:0] lo;
  logic [COST_WIDTH-1:0] diff;
  logic [CORR_WIDTH-1:0] corr;
  logic [COST_WIDTH-1:0] merged;

  always_comb begin
    lo   = (a < b) ? a : b;
    diff = (a < b) ? b - a : a - b;
    corr = '0;
    if (diff < COST_WIDTH'(CORRECTION_DEPTH)) begin
      corr = CORR[diff[IW-1:0]*CORR_WIDTH +: CORR_WIDTH];
    end
    merged = (lo > COST_WIDTH'(corr)) ? lo - COST_WIDTH'(corr) : '0;
    if (a == IMP) begin
      y = b;
    end else if (b == IMP) begin
      y = a;
    end else begin
      y = merged;
    end
  end

endmodule

@@ rtl/hfl_step.sv @@
// One forward step: emission lookup, transitions, merges and the final sequence cost.
// Pure logic between the symbol register and the alpha and result registers.
// Depends on hfl_pkg and hfl_lse.
module hfl_step
  import hfl_pkg::*;
#(
  parameter int COST_WIDTH       = 32,
  parameter int CORRECTION_DEPTH = 256
) (
  input  sym_t                  sym,
  input  cfg_t                  cfg,
  input  logic [COST_WIDTH-1:0] alpha_first,
  input  logic [COST_WIDTH-1:0] alpha_second,
  output logic [COST_WIDTH-1:0] alpha_first_next,
  output logic [COST_WIDTH-1:0] alpha_second_next,
  output res_t                  res_next
);

  localparam logic [COST_WIDTH-1:0] IMP = '1;

  function automatic logic [COST_WIDTH-1:0] cfg_cost(input logic [COST_CFG_WIDTH-1:0] v);
    return (v == CFG_COST_IMP) ? IMP : COST_WIDTH'(v);
  endfunction

  function automatic logic [COST_WIDTH-1:0] emit_cost(input logic [EMIT_TAB_WIDTH-1:0] tab,
                                                      input logic [FACE_WIDTH-1:0] face);
    logic [EMIT_WIDTH-1:0] e;
    case (face)
      3'd1:    e = tab[0*EMIT_WIDTH +: EMIT_WIDTH];
      3'd2:    e = tab[1*EMIT_WIDTH +: EMIT_WIDTH];
      3'd3:    e = tab[2*EMIT_WIDTH +: EMIT_WIDTH];
      3'd4:    e = tab[3*EMIT_WIDTH +: EMIT_WIDTH];
      3'd5:    e = tab[4*EMIT_WIDTH +: EMIT_WIDTH];
      3'd6:    e = tab[5*EMIT_WIDTH +: EMIT_WIDTH];
      default: e = EMIT_IMP;
    endcase
    return (e == EMIT_IMP) ? IMP : COST_WIDTH'(e);
  endfunction

  function automatic logic [COST_WIDTH-1:0] sat_add(input logic [COST_WIDTH-1:0] a,
                                                    input logic [COST_WIDTH-1:0] b);
    logic [COST_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == IMP || b == IMP || s >= {1'b0, IMP}) begin
      return IMP;
    end
    return s[COST_WIDTH-1:0];
  endfunction

  logic [COST_WIDTH-1:0] emit_first;
  logic [COST_WIDTH-1:0] emit_second;
  logic [COST_WIDTH-1:0] ff_cost;
  logic [COST_WIDTH-1:0] sf_cost;
  logic [COST_WIDTH-1:0] fs_cost;
  logic [COST_WIDTH-1:0] ss_cost;
  logic [COST_WIDTH-1:0] merge_first;
  logic [COST_WIDTH-1:0] merge_second;
  logic [COST_WIDTH-1:0] total;
  logic                  over;

  assign emit_first  = emit_cost(cfg.emit_table_first, sym.face);
  assign emit_second = emit_cost(cfg.emit_table_second, sym.face);
  assign ff_cost = sat_add(alpha_first, cfg_cost(cfg.cost_stay_first));
  assign sf_cost = sat_add(alpha_second, cfg_cost(cfg.cost_second_to_first));
  assign fs_cost = sat_add(alpha_first, cfg_cost(cfg.cost_first_to_second));
  assign ss_cost = sat_add(alpha_second, cfg_cost(cfg.cost_stay_second));

  hfl_lse #(
    .COST_WIDTH       (COST_WIDTH),
    .CORRECTION_DEPTH (CORRECTION_DEPTH)
  ) u_lse_first (
    .a (ff_cost),
    .b (sf_cost),
    .y (merge_first)
  );

  hfl_lse #(
    .COST_WIDTH       (COST_WIDTH),
    .CORRECTION_DEPTH (CORRECTION_DEPTH)
  ) u_lse_second (
    .a (fs_cost),
    .b (ss_cost),
    .y (merge_second)
  );

  always_comb begin
    if (sym.first_symbol) begin
      alpha_first_next  = sat_add(cfg_cost(cfg.start_cost_first), emit_first);
      alpha_second_next = sat_add(cfg_cost(cfg.start_cost_second), emit_second);
    end else begin
      alpha_first_next  = sat_add(emit_first, merge_first);
      alpha_second_next = sat_add(emit_second, merge_second);
    end
  end

  hfl_lse #(
    .COST_WIDTH       (COST_WIDTH),
    .CORRECTION_DEPTH (CORRECTION_DEPTH)
  ) u_lse_total (
    .a (alpha_first_next),
    .b (alpha_second_next),
    .y (total)
  );

  assign over = (total == IMP) || (total > COST_WIDTH'(33'h0_FFFF_FFFF));

  always_comb begin
    res_next.impossible    = over;
    res_next.sequence_cost = over ? '1 : SEQ_WIDTH'(total);
  end

endmodule

@@ rtl/hmm_forward_log_likelihood.sv @@
// Two-state HMM forward cost over a stream of die faces, log-space fixed point.
// Symbol channel sym (valid/ready), result channel res (valid/ready), write-only
// configuration port cfg_we/cfg_addr/cfg_data. Depends on hfl_pkg and hfl_step.
//
// Usage:
//   Send one sym item per face; set first_symbol on the face that starts a
//   sequence and last_symbol on the face that ends it. Only a last_symbol item
//   yields a res item: the sequence cost in 1/256 nat, or all ones with
//   impossible set.
//   A taken sym item is held in sym_q; its res item is registered on advance.
//   Throughput: one sym item per cycle unless a last_symbol item stalls; the
//   recurrence step, three log-sum-exp merges with their correction lookups,
//   sits between the symbol register and the alpha and result registers.
//   Stall: while res waits for res_ready, items without last_symbol keep
//   flowing; a last_symbol item holds in the symbol register until the result
//   register frees.
//   Reset: rst (synchronous) restores the register defaults, sets both alphas
//   to impossible and empties both registers. No clearing pass is needed. Write
//   configuration only while no item is in flight; the block does not enforce it.
module hmm_forward_log_likelihood
  import hfl_pkg::*;
#(
  parameter int COST_WIDTH       = 32,
  parameter int CORRECTION_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sym_valid,
  output logic                  sym_ready,
  input  sym_t                  sym,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  cfg_we,
  input  logic [ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]  cfg_data
);

  localparam logic [COST_WIDTH-1:0] IMP = '1;

  cfg_t                  cfg;
  sym_t                  sym_q;
  logic                  sym_q_valid;
  logic                  advance;
  logic [COST_WIDTH-1:0] alpha_first;
  logic [COST_WIDTH-1:0] alpha_second;
  logic [COST_WIDTH-1:0] alpha_first_next;
  logic [COST_WIDTH-1:0] alpha_second_next;
  res_t                  res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cost_stay_first      <= RST_COST_STAY_FIRST;
      cfg.cost_first_to_second <= RST_COST_FIRST_TO_SECOND;
      cfg.cost_second_to_first <= RST_COST_SECOND_TO_FIRST;
      cfg.cost_stay_second     <= RST_COST_STAY_SECOND;
      cfg.emit_table_first     <= RST_EMIT_TABLE_FIRST;
      cfg.emit_table_second    <= RST_EMIT_TABLE_SECOND;
      cfg.start_cost_first     <= RST_START_COST_FIRST;
      cfg.start_cost_second    <= RST_START_COST_SECOND;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COST_STAY_FIRST:      cfg.cost_stay_first      <= cfg_data[COST_CFG_WIDTH-1:0];
        REG_COST_FIRST_TO_SECOND: cfg.cost_first_to_second <= cfg_data[COST_CFG_WIDTH-1:0];
        REG_COST_SECOND_TO_FIRST: cfg.cost_second_to_first <= cfg_data[COST_CFG_WIDTH-1:0];
        REG_COST_STAY_SECOND:     cfg.cost_stay_second     <= cfg_data[COST_CFG_WIDTH-1:0];
        REG_EMIT_TABLE_FIRST:     cfg.emit_table_first     <= cfg_data[EMIT_TAB_WIDTH-1:0];
        REG_EMIT_TABLE_SECOND:    cfg.emit_table_second    <= cfg_data[EMIT_TAB_WIDTH-1:0];
        REG_START_COST_FIRST:     cfg.start_cost_first     <= cfg_data[COST_CFG_WIDTH-1:0];
        REG_START_COST_SECOND:    cfg.start_cost_second    <= cfg_data[COST_CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance the held item unless it has a result and the result register is blocked
  assign advance   = sym_q_valid && (!sym_q.last_symbol || !res_valid || res_ready);
  assign sym_ready = !sym_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_q_valid <= 1'b0;
    end else if (sym_ready) begin
      sym_q_valid <= sym_valid;
    end
    if (sym_valid && sym_ready) begin
      sym_q <= sym;
    end
  end

  hfl_step #(
    .COST_WIDTH       (COST_WIDTH),
    .CORRECTION_DEPTH (CORRECTION_DEPTH)
  ) u_step (
    .sym               (sym_q),
    .cfg               (cfg),
    .alpha_first       (alpha_first),
    .alpha_second      (alpha_second),
    .alpha_first_next  (alpha_first_next),
    .alpha_second_next (alpha_second_next),
    .res_next          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_first  <= IMP;
      alpha_second <= IMP;
    end else if (advance) begin
      alpha_first  <= alpha_first_next;
      alpha_second <= alpha_second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && sym_q.last_symbol) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (advance && sym_q.last_symbol) begin
      res <= res_next;
    end
  end

  a_reset_alpha: assert property (@(posedge clk)
    $past(rst) |-> (alpha_first == IMP && alpha_second == IMP))
    else $error("alphas not impossible after reset");

  a_alpha_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(alpha_first) && $stable(alpha_second)))
    else $error("alpha changed without an advancing item");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && sym_q.last_symbol) |=> res_valid)
    else $error("last item advanced without a result");

  a_impossible_cost: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.impossible) |-> (res.sequence_cost == '1))
    else $error("impossible result without all-ones cost");

endmodule

@@ dv/hfl_forward_checker.sv @@
// Passive checker for the two-state HMM forward cost block: tracks the config
// writes, predicts each sequence cost and compares it with the result channel.
// Depends on hfl_pkg.
module hfl_forward_checker
  import hfl_pkg::*;
#(
  parameter int COST_WIDTH       = 32,
  parameter int CORRECTION_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sym_valid,
  input  logic                  sym_ready,
  input  sym_t                  sym,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  res_t                  res,
  input  logic                  cfg_we,
  input  logic [ADDR_WIDTH-1:0] cfg_addr,
  input  logic [CFG_WIDTH-1:0]  cfg_data,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] COST_IMP  = (64'd1 << COST_WIDTH) - 64'd1;
  localparam int          DECAY_LEN = 2 * CORRECTION_DEPTH + 2 * MAX_CORR + 2;

  logic [63:0]           decay [DECAY_LEN];
  logic [CORR_WIDTH-1:0] merge_fix [CORRECTION_DEPTH];

  cfg_t        regs;
  logic [63:0] alpha_first;
  logic [63:0] alpha_second;
  res_t        cost_q [$];

  function automatic bit fix_holds(int k, logic [63:0] y);
    logic [127:0] prod;
    logic [63:0]  z;
    z    = decay[2 * k - 1];
    prod = {64'd0, y} * {64'd0, z};
    return (z + prod[95:32]) >= ONE_Q32;
  endfunction

  initial begin : build_fix
    logic [127:0] prod;
    int c;
    decay[0] = ONE_Q32;
    for (int m = 1; m < DECAY_LEN; m++) begin
      prod     = {64'd0, decay[m - 1]} * {64'd0, STEP_Q32};
      decay[m] = prod[95:32];
    end
    c = 0;
    while (c < MAX_CORR && fix_holds(c + 1, decay[0])) c++;
    merge_fix[0] = CORR_WIDTH'(c);
    for (int d = 1; d < CORRECTION_DEPTH; d++) begin
      while (c > 0 && !fix_holds(c, decay[2 * d])) c--;
      merge_fix[d] = CORR_WIDTH'(c);
    end
  end

  function automatic logic [63:0] reg_cost(logic [COST_CFG_WIDTH-1:0] v);
    return (v == CFG_COST_IMP) ? COST_IMP : {48'd0, v};
  endfunction

  function automatic logic [63:0] emission(logic [EMIT_TAB_WIDTH-1:0] tab,
                                           logic [FACE_WIDTH-1:0] f);
    logic [EMIT_WIDTH-1:0] e;
    int base;
    if (f < 1 || f > 6) return COST_IMP;
    base = (int'(f) - 1) * EMIT_WIDTH;
    e    = tab[base +: EMIT_WIDTH];
    return (e == EMIT_IMP) ? COST_IMP : {54'd0, e};
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    if (a >= COST_IMP || b >= COST_IMP) return COST_IMP;
    s = a + b;
    return (s >= COST_IMP) ? COST_IMP : s;
  endfunction

  function automatic logic [63:0] log_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] lo, d, c;
    if (a >= COST_IMP) return b;
    if (b >= COST_IMP) return a;
    lo = (a < b) ? a : b;
    d  = (a < b) ? b - a : a - b;
    c  = (d < CORRECTION_DEPTH) ? {56'd0, merge_fix[d]} : 64'd0;
    return (lo > c) ? lo - c : 64'd0;
  endfunction

  always @(posedge clk) begin : watch
    res_t        want;
    logic [63:0] e1, e2, n1, n2, total;
    if (rst) begin
      regs.cost_stay_first      = RST_COST_STAY_FIRST;
      regs.cost_first_to_second = RST_COST_FIRST_TO_SECOND;
      regs.cost_second_to_first = RST_COST_SECOND_TO_FIRST;
      regs.cost_stay_second     = RST_COST_STAY_SECOND;
      regs.emit_table_first     = RST_EMIT_TABLE_FIRST;
      regs.emit_table_second    = RST_EMIT_TABLE_SECOND;
      regs.start_cost_first     = RST_START_COST_FIRST;
      regs.start_cost_second    = RST_START_COST_SECOND;
      alpha_first  = COST_IMP;
      alpha_second = COST_IMP;
      cost_q.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_COST_STAY_FIRST:      regs.cost_stay_first      = cfg_data[COST_CFG_WIDTH-1:0];
          REG_COST_FIRST_TO_SECOND: regs.cost_first_to_second = cfg_data[COST_CFG_WIDTH-1:0];
          REG_COST_SECOND_TO_FIRST: regs.cost_second_to_first = cfg_data[COST_CFG_WIDTH-1:0];
          REG_COST_STAY_SECOND:     regs.cost_stay_second     = cfg_data[COST_CFG_WIDTH-1:0];
          REG_EMIT_TABLE_FIRST:     regs.emit_table_first     = cfg_data[EMIT_TAB_WIDTH-1:0];
          REG_EMIT_TABLE_SECOND:    regs.emit_table_second    = cfg_data[EMIT_TAB_WIDTH-1:0];
          REG_START_COST_FIRST:     regs.start_cost_first     = cfg_data[COST_CFG_WIDTH-1:0];
          REG_START_COST_SECOND:    regs.start_cost_second    = cfg_data[COST_CFG_WIDTH-1:0];
          default: ;
        endcase
      end

      if (res_valid && res_ready) begin
        if (cost_q.size() == 0) begin
          $error("result item with no prediction pending: sequence_cost %0d impossible %0d",
                 res.sequence_cost, res.impossible);
          fails++;
        end else begin
          want = cost_q.pop_front();
          if (res.sequence_cost !== want.sequence_cost) begin
            $error("sequence_cost: expected %0d, got %0d", want.sequence_cost,
                   res.sequence_cost);
            fails++;
          end
          if (res.impossible !== want.impossible) begin
            $error("impossible: expected %0d, got %0d", want.impossible, res.impossible);
            fails++;
          end
        end
      end

      if (sym_valid && sym_ready) begin
        e1 = emission(regs.emit_table_first, sym.face);
        e2 = emission(regs.emit_table_second, sym.face);
        if (sym.first_symbol) begin
          n1 = add_sat(reg_cost(regs.start_cost_first), e1);
          n2 = add_sat(reg_cost(regs.start_cost_second), e2);
        end else begin
          n1 = add_sat(e1, log_add(add_sat(alpha_first, reg_cost(regs.cost_stay_first)),
                                   add_sat(alpha_second, reg_cost(regs.cost_second_to_first))));
          n2 = add_sat(e2, log_add(add_sat(alpha_first, reg_cost(regs.cost_first_to_second)),
                                   add_sat(alpha_second, reg_cost(regs.cost_stay_second))));
        end
        alpha_first  = n1;
        alpha_second = n2;
        if (sym.last_symbol) begin
          total = log_add(n1, n2);
          if (total >= COST_IMP || total > 64'hFFFF_FFFF) begin
            want.sequence_cost = '1;
            want.impossible    = 1'b1;
          end else begin
            want.sequence_cost = total[SEQ_WIDTH-1:0];
            want.impossible    = 1'b0;
          end
          cost_q.push_back(want);
        end
      end
      pending = cost_q.size();
    end
  end

endmodule

@@ dv/tb_hmm_forward_log_likelihood.sv @@
// Top of the HMM forward cost testbench: clock, reset, symbol and config
// stimulus, result-side back-pressure and the verdict.
// Depends on hfl_pkg, hmm_forward_log_likelihood and hfl_forward_checker.
module tb_hmm_forward_log_likelihood
  import hfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COST_W       = 32;
  localparam int CORR_DEPTH   = 256;
  localparam int PHASE_ITEMS  = 180;
  localparam int HOLD_CYCLES  = 60;
  localparam int BURST_ITEMS  = 24;
  localparam int LONG_RUN     = 120;
  localparam int LONG_MID     = 60;
  localparam int FACES        = 6;
  localparam int CYCLE_LIMIT  = 100000;

  typedef enum {CFG_MIX, CFG_ZERO, CFG_TOP, CFG_FULL, CFG_EDGE} cfg_mode_e;

  cfg_mode_e phase_mode [6] = '{CFG_MIX, CFG_ZERO, CFG_MIX, CFG_TOP, CFG_FULL, CFG_EDGE};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  sym_valid = 1'b0;
  logic                  sym_ready;
  sym_t                  sym       = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  res_t                  res;
  logic                  cfg_we    = 1'b0;
  logic [ADDR_WIDTH-1:0] cfg_addr  = '0;
  logic [CFG_WIDTH-1:0]  cfg_data  = '0;

  int fails;
  int pending;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  hmm_forward_log_likelihood #(
    .COST_WIDTH      (COST_W),
    .CORRECTION_DEPTH(CORR_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .sym_valid(sym_valid),
    .sym_ready(sym_ready),
    .sym      (sym),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  hfl_forward_checker #(
    .COST_WIDTH      (COST_W),
    .CORRECTION_DEPTH(CORR_DEPTH)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .sym_valid(sym_valid),
    .sym_ready(sym_ready),
    .sym      (sym),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always begin
    @(negedge clk);
    if (hold_req) begin
      hold_req  = 1'b0;
      res_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
    end
    res_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic sym_t symbol_of(logic [FACE_WIDTH-1:0] f, bit first, bit last);
    sym_t s;
    s.face         = f;
    s.first_symbol = first;
    s.last_symbol  = last;
    return s;
  endfunction

  task automatic send_sym(sym_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sym_valid = 1'b0;
      @(negedge clk);
    end
    sym_valid = 1'b1;
    sym       = s;
    do @(posedge clk); while (!sym_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    sym_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [ADDR_WIDTH-1:0] addr, logic [CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [CFG_WIDTH-1:0] pick_cost(cfg_mode_e mode);
    case (mode)
      CFG_ZERO: return '0;
      CFG_TOP:  return CFG_WIDTH'(CFG_COST_IMP);
      CFG_EDGE: return CFG_WIDTH'(CFG_COST_IMP - 1);
      CFG_FULL: return CFG_WIDTH'({$urandom, $urandom});
      default: begin
        case ($urandom_range(7))
          0:       return CFG_WIDTH'(CFG_COST_IMP);
          1:       return '0;
          default: return CFG_WIDTH'($urandom_range(3000));
        endcase
      end
    endcase
  endfunction

  function automatic logic [EMIT_TAB_WIDTH-1:0] pick_table(cfg_mode_e mode);
    logic [EMIT_TAB_WIDTH-1:0] t;
    t = '0;
    for (int k = 0; k < FACES; k++) begin
      case (mode)
        CFG_ZERO: t[k*EMIT_WIDTH +: EMIT_WIDTH] = '0;
        CFG_TOP:  t[k*EMIT_WIDTH +: EMIT_WIDTH] = EMIT_IMP;
        CFG_EDGE: t[k*EMIT_WIDTH +: EMIT_WIDTH] = EMIT_WIDTH'(EMIT_IMP - 1);
        CFG_FULL: t[k*EMIT_WIDTH +: EMIT_WIDTH] = EMIT_WIDTH'($urandom);
        default:  t[k*EMIT_WIDTH +: EMIT_WIDTH] = ($urandom_range(9) == 0) ? EMIT_IMP :
                                                  EMIT_WIDTH'($urandom_range(EMIT_IMP - 1));
      endcase
    end
    return t;
  endfunction

  task automatic load_config(cfg_mode_e mode);
    write_reg(REG_COST_STAY_FIRST, pick_cost(mode));
    write_reg(REG_COST_FIRST_TO_SECOND, pick_cost(mode));
    write_reg(REG_COST_SECOND_TO_FIRST, pick_cost(mode));
    write_reg(REG_COST_STAY_SECOND, pick_cost(mode));
    write_reg(REG_EMIT_TABLE_FIRST, CFG_WIDTH'(pick_table(mode)));
    write_reg(REG_EMIT_TABLE_SECOND, CFG_WIDTH'(pick_table(mode)));
    write_reg(REG_START_COST_FIRST, pick_cost(mode));
    write_reg(REG_START_COST_SECOND, pick_cost(mode));
  endtask

  initial begin : stimulus
    int   sent;
    int   len;
    sym_t s;
    send_idle_pct  = 14;
    recv_stall_pct = 83;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, under the reset configuration
    send_sym(symbol_of(3'd1, 1'b1, 1'b1));
    send_sym(symbol_of(3'd1, 1'b1, 1'b0));
    for (int f = 2; f <= FACES; f++) send_sym(symbol_of(FACE_WIDTH'(f), 1'b0, f == FACES));
    send_sym(symbol_of(3'd6, 1'b0, 1'b1));
    send_sym(symbol_of(3'd0, 1'b1, 1'b1));
    send_sym(symbol_of(3'd7, 1'b1, 1'b1));
    send_sym(symbol_of(3'd3, 1'b0, 1'b0));
    send_sym(symbol_of(3'd2, 1'b0, 1'b1));
    send_sym(symbol_of(3'd4, 1'b1, 1'b0));
    send_sym(symbol_of(3'd5, 1'b0, 1'b0));
    send_sym(symbol_of(3'd6, 1'b0, 1'b1));
    send_sym(symbol_of(3'd2, 1'b1, 1'b1));
    drain();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct  = (p < 2) ? 14 : (p < 4) ? 83 : 0;
      recv_stall_pct = (p < 2) ? 83 : (p < 4) ? 14 : 0;
      load_config(phase_mode[p]);
      if (p == 4) begin
        hold_req = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++)
          send_sym(symbol_of(FACE_WIDTH'($urandom_range(7)), 1'b1, 1'b1));
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          s.face         = FACE_WIDTH'($urandom_range(7));
          s.first_symbol = 1'($urandom_range(1));
          s.last_symbol  = 1'($urandom_range(1));
          send_sym(s);
          sent++;
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
          for (int i = 0; i < len; i++) begin
            s.face = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 3'd7 : 3'd0) :
                     FACE_WIDTH'($urandom_range(FACES, 1));
            s.first_symbol = (i == 0);
            s.last_symbol  = (i == len - 1);
            send_sym(s);
            sent++;
          end
        end
      end
      drain();
    end

    // one long sequence at the largest finite costs, with a result midway
    for (int i = 0; i < LONG_RUN; i++)
      send_sym(symbol_of(FACE_WIDTH'($urandom_range(FACES, 1)), i == 0,
                         i == LONG_MID - 1 || i == LONG_RUN - 1));
    drain();

    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hfl_pkg.sv
rtl/hfl_lse.sv
rtl/hfl_step.sv
rtl/hmm_forward_log_likelihood.sv
dv/hfl_forward_checker.sv
dv/tb_hmm_forward_log_likelihood.sv
